// ===== hw/rtl/quadrature_position_tracker_assert.svh =====
// Assertion macros shared by the position tracker RTL.
// Needs nothing else; files that check their logic include it.
`ifndef QUADRATURE_POSITION_TRACKER_ASSERT_SVH
`define QUADRATURE_POSITION_TRACKER_ASSERT_SVH

// same-cycle implication
`define QPT_ASSERT_NOW(label, clk, rst_n, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
        else $error(msg);

// next-cycle implication
`define QPT_ASSERT_NEXT(label, clk, rst_n, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
        else $error(msg);

`endif

// ===== hw/rtl/qpt_pkg.sv =====
// Shared types and constants for the quadrature position tracker.
// No dependencies.
package qpt_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int HOME_W   = 16;
    localparam int NEEDLE_W = 14;
    localparam int SKIP_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [HOME_W-1:0] LEFT_HOME_RESET  = 16'sd0;
    localparam logic signed [HOME_W-1:0] RIGHT_HOME_RESET = 16'sd794;
    localparam logic [1:0]               PHASE_RESET      = 2'd3;
    localparam logic [SKIP_W-1:0]        SKIP_MAX         = {SKIP_W{1'b1}};
    localparam int NEEDLE_MAX = 8191;
    localparam int NEEDLE_MIN = -8192;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_HOME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_HOME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_EN  = 2'd2;

    typedef enum logic [1:0] {
        FUNC_LEFT_HOME  = 2'd0,
        FUNC_RIGHT_HOME = 2'd1,
        FUNC_ENCODER    = 2'd2,
        FUNC_OTHER      = 2'd3
    } qpt_func_t;

    typedef struct packed {
        qpt_func_t func;
        logic      level;
        logic      enc_a;
        logic      enc_b;
        logic      belt_sensor;
    } qpt_item_t;

    typedef struct packed {
        logic signed [HOME_W-1:0] left_home_count;
        logic signed [HOME_W-1:0] right_home_count;
        logic                     report_enable;
    } qpt_cfg_t;

    typedef struct packed {
        logic signed [NEEDLE_W-1:0] needle;
        logic                       phase_of_belt;
        logic [SKIP_W-1:0]          skipped_steps;
    } qpt_result_t;

endpackage

// ===== hw/rtl/qpt_cfg.sv =====
// Configuration register file: home counts and report enable.
// Depends on qpt_pkg.
module qpt_cfg
    import qpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [HOME_W-1:0]     wr_data,
    output qpt_cfg_t              cfg
);

    qpt_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_home_count  <= LEFT_HOME_RESET;
            cfg_reg.right_home_count <= RIGHT_HOME_RESET;
            cfg_reg.report_enable    <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_LEFT_HOME:  cfg_reg.left_home_count  <= signed'(wr_data);
                CFG_RIGHT_HOME: cfg_reg.right_home_count <= signed'(wr_data);
                CFG_REPORT_EN:  cfg_reg.report_enable    <= wr_data[0];
                default: ; // unmapped index, dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/qpt_tracker.sv =====
// Position state and its per-event update: homing, quadrature step, report check.
// Depends on qpt_pkg and the assertion macro header.
`include "quadrature_position_tracker_assert.svh"

module qpt_tracker
    import qpt_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        proc,
    input  qpt_item_t   item,
    input  qpt_cfg_t    cfg,
    output logic        emit,
    output qpt_result_t result
);

    // wide enough for home counts, count limits and the needle limits
    localparam int EW = ((COUNT_WIDTH > HOME_W) ? COUNT_WIDTH : HOME_W) + 1;

    localparam logic signed [COUNT_WIDTH-1:0] CMAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CMIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam logic signed [EW-1:0] CMAX_E = EW'(CMAX);
    localparam logic signed [EW-1:0] CMIN_E = EW'(CMIN);
    localparam logic signed [EW-1:0] NMAX_E = EW'(NEEDLE_MAX);
    localparam logic signed [EW-1:0] NMIN_E = EW'(NEEDLE_MIN);
    localparam logic signed [EW-1:0] BIAS   = EW'(3);

    logic signed [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [1:0]                    phase_reg, phase_next;
    logic                          known_reg, known_next;
    logic [SKIP_W-1:0]             skip_reg, skip_next;
    logic                          belt_reg, belt_next;
    logic signed [NEEDLE_W-1:0]    reported_reg;
    logic                          any_reported_reg;

    logic                          homing;
    logic [1:0]                    ph;
    logic signed [HOME_W-1:0]      home_sel;
    logic signed [EW-1:0]          home_ext;
    logic signed [COUNT_WIDTH-1:0] home_clamped;
    logic signed [EW-1:0]          biased;
    logic signed [EW-1:0]          quot;
    logic signed [NEEDLE_W-1:0]    needle;
    logic                          report;

    always_comb
    begin
        homing   = ((item.func == FUNC_LEFT_HOME) || (item.func == FUNC_RIGHT_HOME))
                   && !item.level;
        // Gray decode: a | b<<1 with codes 2 and 3 swapped
        ph       = {item.enc_b, item.enc_a ^ item.enc_b};
        home_sel = (item.func == FUNC_LEFT_HOME) ? cfg.left_home_count
                                                 : cfg.right_home_count;
        home_ext = EW'(home_sel);
        if (home_ext > CMAX_E)
            home_clamped = CMAX;
        else if (home_ext < CMIN_E)
            home_clamped = CMIN;
        else
            home_clamped = home_ext[COUNT_WIDTH-1:0];

        count_next = count_reg;
        phase_next = phase_reg;
        known_next = known_reg;
        skip_next  = skip_reg;
        belt_next  = belt_reg;

        case (item.func)
            FUNC_LEFT_HOME, FUNC_RIGHT_HOME:
            begin
                if (!item.level)
                begin
                    belt_next  = (item.func == FUNC_LEFT_HOME) ? item.belt_sensor
                                                               : ~item.belt_sensor;
                    count_next = home_clamped;
                    skip_next  = '0;
                    known_next = 1'b1;
                end
            end
            FUNC_ENCODER:
            begin
                if (ph == phase_reg + 2'd1)
                begin
                    if (count_reg != CMIN)
                        count_next = count_reg - COUNT_WIDTH'(1);
                end
                else if (ph == phase_reg - 2'd1)
                begin
                    if (count_reg != CMAX)
                        count_next = count_reg + COUNT_WIDTH'(1);
                end
                else if (skip_reg != SKIP_MAX)
                begin
                    skip_next = skip_reg + SKIP_W'(1);
                end
                phase_next = ph;
            end
            default: ;
        endcase

        // divide by four toward zero: bias negatives by three, then shift
        biased = EW'(count_next) + (count_next[COUNT_WIDTH-1] ? BIAS : '0);
        quot   = biased >>> 2;
        if (quot > NMAX_E)
            needle = NMAX_E[NEEDLE_W-1:0];
        else if (quot < NMIN_E)
            needle = NMIN_E[NEEDLE_W-1:0];
        else
            needle = quot[NEEDLE_W-1:0];

        report = cfg.report_enable && known_next
                 && !(any_reported_reg && (needle == reported_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            phase_reg        <= PHASE_RESET;
            known_reg        <= 1'b0;
            skip_reg         <= '0;
            belt_reg         <= 1'b0;
            reported_reg     <= '0;
            any_reported_reg <= 1'b0;
        end
        else if (proc)
        begin
            count_reg <= count_next;
            phase_reg <= phase_next;
            known_reg <= known_next;
            skip_reg  <= skip_next;
            belt_reg  <= belt_next;
            if (report)
            begin
                reported_reg     <= needle;
                any_reported_reg <= 1'b1;
            end
        end
    end

    assign emit                 = proc && report;
    assign result.needle        = needle;
    assign result.phase_of_belt = belt_next;
    assign result.skipped_steps = skip_next;

    `QPT_ASSERT_NEXT(a_home_clears_skip, clk, rst_n, proc && homing,
        (skip_reg == '0) && known_reg, "homing must clear skips and mark position")
    `QPT_ASSERT_NEXT(a_report_tracked, clk, rst_n, emit,
        any_reported_reg && (reported_reg == $past(needle)), "last report not recorded")
    `QPT_ASSERT_NOW(a_no_report_unknown, clk, rst_n, emit,
        known_next && cfg.report_enable, "report without valid position")

endmodule

// ===== hw/rtl/quadrature_position_tracker.sv =====
// Quadrature encoder position tracker with left/right homing: top level.
// Depends on qpt_pkg, qpt_cfg, qpt_tracker and the assertion macro header.
//
// One request per cycle while the output is not stalled: a request is captured in
// an input register, updated against the position state once the output register
// is free, and its report, if any, lands in the output register. The state update
// (step, saturate, divide by four and compare with the last report) is
// combinational. A stalled output holds one report while one more request waits
// in the input register; the configuration port takes writes whenever no request
// is pending.
`include "quadrature_position_tracker_assert.svh"

module quadrature_position_tracker
    import qpt_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 func,
    input  logic                       level,
    input  logic                       enc_a,
    input  logic                       enc_b,
    input  logic                       belt_sensor,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [NEEDLE_W-1:0] needle,
    output logic                       phase_of_belt,
    output logic [SKIP_W-1:0]          skipped_steps,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [HOME_W-1:0]          cfg_data
);

    logic        in_valid_reg;
    qpt_item_t   item_reg;
    logic        out_valid_reg;
    qpt_result_t result_reg;

    logic        out_free;
    logic        proc;
    logic        in_take;
    logic        emit;
    qpt_result_t result;
    qpt_cfg_t    cfg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign proc      = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = !in_valid_reg;

    qpt_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    qpt_tracker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .proc   (proc),
        .item   (item_reg),
        .cfg    (cfg),
        .emit   (emit),
        .result (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (proc)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.func        <= qpt_func_t'(func);
            item_reg.level       <= level;
            item_reg.enc_a       <= enc_a;
            item_reg.enc_b       <= enc_b;
            item_reg.belt_sensor <= belt_sensor;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            result_reg <= result;
    end

    assign out_valid     = out_valid_reg;
    assign needle        = result_reg.needle;
    assign phase_of_belt = result_reg.phase_of_belt;
    assign skipped_steps = result_reg.skipped_steps;

    `QPT_ASSERT_NEXT(a_blocked_item_held, clk, rst_n, in_valid_reg && !out_free,
        in_valid_reg && $stable(item_reg), "pending request lost while output blocked")
    `QPT_ASSERT_NEXT(a_emit_lands, clk, rst_n, emit,
        out_valid_reg, "report not loaded into output register")
    `QPT_ASSERT_NOW(a_emit_needs_slot, clk, rst_n, emit,
        out_free, "report produced with output register occupied")

endmodule
